/* rtl/prla_pkg.sv */
// ----------------------------------------------------------------------------
// prla_pkg
// Shared types, constants and codes for the priority round-robin lane arbiter.
// ----------------------------------------------------------------------------
package prla_pkg;

	localparam int LANE_COUNT   = 4;
	localparam int LANE_BITS    = $clog2(LANE_COUNT);
	localparam int COUNT_BITS   = $clog2(LANE_COUNT + 1);
	localparam int QUEUE_BITS   = 8;
	localparam int AGE_BITS     = 8;
	localparam int CFG_BITS     = 8;
	localparam int QUANTUM_BITS = 4;
	localparam int CLASS_BITS   = 2;
	localparam int OP_BITS      = 2;
	localparam int MODE_BITS    = 2;
	localparam int INDEX_BITS   = 3;
	localparam int LOAD_BITS    = QUEUE_BITS + COUNT_BITS;
	localparam int PROD_BITS    = CFG_BITS + COUNT_BITS;
	localparam int CMP_BITS     = (LOAD_BITS > PROD_BITS) ? LOAD_BITS : PROD_BITS;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// operation codes
	localparam logic [OP_BITS-1:0] OP_SCHEDULE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_PREEMPT  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_SERVICE  = 2'd2;
	localparam logic [OP_BITS-1:0] OP_TICK     = 2'd3;

	// mode codes
	localparam logic [MODE_BITS-1:0] MODE_PLAIN    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_AGING    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_ADAPTIVE = 2'd2;

	// grant classes
	localparam logic [CLASS_BITS-1:0] CLASS_EMERGENCY = 2'd0;
	localparam logic [CLASS_BITS-1:0] CLASS_NORMAL    = 2'd1;
	localparam logic [CLASS_BITS-1:0] CLASS_LOW       = 2'd2;

	// configuration register indexes
	localparam logic [INDEX_BITS-1:0] REG_MODE       = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_BUSY_THRESH = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_AGING_LIMIT = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_HEAVY_AVG  = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_LIGHT_AVG  = 3'd4;
	localparam logic [INDEX_BITS-1:0] REG_Q_DEFAULT  = 3'd5;
	localparam logic [INDEX_BITS-1:0] REG_Q_HEAVY    = 3'd6;
	localparam logic [INDEX_BITS-1:0] REG_Q_LIGHT    = 3'd7;

	typedef struct packed {
		logic [MODE_BITS-1:0]    mode;
		logic [CFG_BITS-1:0]     busy_queue_threshold;
		logic [CFG_BITS-1:0]     aging_limit;
		logic [CFG_BITS-1:0]     heavy_load_average;
		logic [CFG_BITS-1:0]     light_load_average;
		logic [QUANTUM_BITS-1:0] quantum_default;
		logic [QUANTUM_BITS-1:0] quantum_heavy;
		logic [QUANTUM_BITS-1:0] quantum_light;
	} cfg_t;

	// what one lane reports to the merge stage
	typedef struct packed {
		logic                  eligible;
		logic [CLASS_BITS-1:0] cls;
		logic                  ready;
		logic [QUEUE_BITS-1:0] load;
	} lane_info_t;

	typedef struct packed {
		logic                    found;
		logic [LANE_BITS-1:0]    lane;
		logic [CLASS_BITS-1:0]   cls;
		logic [LANE_BITS-1:0]    next_pointer;
		logic [QUANTUM_BITS-1:0] quantum;
	} pick_t;

endpackage

/* rtl/prla_lane.sv */
// ----------------------------------------------------------------------------
// prla_lane
// One lane: class and eligibility of the lane, its load share and next age.
// ----------------------------------------------------------------------------
module prla_lane (
	input  prla_pkg::cfg_t                       cfg,
	input  logic [prla_pkg::OP_BITS-1:0]         operation,
	input  logic                                 is_target,
	input  logic                                 ready,
	input  logic                                 blocked,
	input  logic                                 emergency,
	input  logic [prla_pkg::QUEUE_BITS-1:0]      lane_queue,
	input  logic [prla_pkg::AGE_BITS-1:0]        age,
	output prla_pkg::lane_info_t                 info,
	output logic [prla_pkg::AGE_BITS-1:0]        age_next
);
	import prla_pkg::*;

	logic busy;
	logic aged;

	assign busy = {{CMP_BITS-QUEUE_BITS{1'b0}}, lane_queue}
		> {{CMP_BITS-CFG_BITS{1'b0}}, cfg.busy_queue_threshold};
	// promotion of a starved low lane only in fair mode
	assign aged = (cfg.mode == MODE_AGING)
		&& ({{CMP_BITS-AGE_BITS{1'b0}}, age} > {{CMP_BITS-CFG_BITS{1'b0}}, cfg.aging_limit});

	always_comb begin
		info.eligible = ready & ~blocked;
		info.ready    = ready;
		info.load     = ready ? lane_queue : '0;
		if (emergency) begin
			info.cls = CLASS_EMERGENCY;
		end else if (busy || aged) begin
			info.cls = CLASS_NORMAL;
		end else begin
			info.cls = CLASS_LOW;
		end
	end

	always_comb begin
		case (operation)
			OP_TICK: begin
				age_next = (age == AGE_MAX) ? age : age + AGE_BITS'(1);
			end
			OP_SERVICE: begin
				age_next = is_target ? '0 : age;
			end
			default: begin
				age_next = age;
			end
		endcase
	end

endmodule

/* rtl/prla_merge.sv */
// ----------------------------------------------------------------------------
// prla_merge
// Merge stage: highest class wins, rotating pick from the shared pointer,
// adaptive quantum from the summed load.
// ----------------------------------------------------------------------------
module prla_merge (
	input  prla_pkg::cfg_t                       cfg,
	input  prla_pkg::lane_info_t                 info [prla_pkg::LANE_COUNT],
	input  logic [prla_pkg::LANE_BITS-1:0]       pointer,
	output prla_pkg::pick_t                      pick
);
	import prla_pkg::*;

	logic [LANE_COUNT-1:0] req_emerg;
	logic [LANE_COUNT-1:0] req_normal;
	logic [LANE_COUNT-1:0] req_low;
	logic [LANE_COUNT-1:0] req_sel;
	logic [CLASS_BITS-1:0] cls_sel;
	logic [LOAD_BITS-1:0]  total;
	logic [COUNT_BITS-1:0] count;
	logic [CMP_BITS-1:0]   heavy_bound;
	logic [CMP_BITS-1:0]   light_bound;
	logic [CMP_BITS-1:0]   total_x;
	logic [LANE_BITS:0]    idx_w;
	logic [LANE_BITS:0]    nxt_w;
	logic [LANE_BITS-1:0]  idx;

	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			req_emerg[i]  = info[i].eligible && (info[i].cls == CLASS_EMERGENCY);
			req_normal[i] = info[i].eligible && (info[i].cls == CLASS_NORMAL);
			req_low[i]    = info[i].eligible && (info[i].cls == CLASS_LOW);
		end
		if (|req_emerg) begin
			req_sel = req_emerg;
			cls_sel = CLASS_EMERGENCY;
		end else if (|req_normal) begin
			req_sel = req_normal;
			cls_sel = CLASS_NORMAL;
		end else begin
			req_sel = req_low;
			cls_sel = CLASS_LOW;
		end
	end

	// load totals over the ready lanes, blocked or not
	always_comb begin
		total = '0;
		count = '0;
		for (int i = 0; i < LANE_COUNT; i++) begin
			total = total + LOAD_BITS'(info[i].load);
			count = count + COUNT_BITS'(info[i].ready);
		end
		total_x     = CMP_BITS'(total);
		heavy_bound = CMP_BITS'(count) * CMP_BITS'(cfg.heavy_load_average);
		light_bound = CMP_BITS'(count) * CMP_BITS'(cfg.light_load_average);
	end

	always_comb begin
		pick.found        = 1'b0;
		pick.lane         = '0;
		pick.cls          = cls_sel;
		pick.next_pointer = pointer;
		idx_w             = '0;
		idx               = '0;
		nxt_w             = '0;
		for (int k = LANE_COUNT - 1; k >= 0; k--) begin
			idx_w = {1'b0, pointer} + (LANE_BITS+1)'(k);
			if (idx_w >= (LANE_BITS+1)'(LANE_COUNT)) begin
				idx_w = idx_w - (LANE_BITS+1)'(LANE_COUNT);
			end
			idx = idx_w[LANE_BITS-1:0];
			// scanned backwards so the nearest request at or after the pointer wins
			if (req_sel[idx]) begin
				pick.found = 1'b1;
				pick.lane  = idx;
			end
		end
		nxt_w = {1'b0, pick.lane} + (LANE_BITS+1)'(1);
		if (nxt_w >= (LANE_BITS+1)'(LANE_COUNT)) begin
			nxt_w = '0;
		end
		if (pick.found) begin
			pick.next_pointer = nxt_w[LANE_BITS-1:0];
		end
		pick.quantum = cfg.quantum_default;
		if (cfg.mode == MODE_ADAPTIVE && count != '0) begin
			if (total_x > heavy_bound) begin
				pick.quantum = cfg.quantum_heavy;
			end else if (total_x < light_bound) begin
				pick.quantum = cfg.quantum_light;
			end
		end
	end

endmodule

/* rtl/priority_round_robin_lane_arbiter_unit.sv */
// ----------------------------------------------------------------------------
// priority_round_robin_lane_arbiter_unit
// Four-lane three-class round-robin arbiter with aging and adaptive quantum.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall with operation, lane masks,
//                    per-lane queue lengths and target_lane. One request per
//                    transaction: schedule, preempt, record service or tick.
//   result channel : result_valid / result_stall; every request gives one
//                    result transaction (grant_valid low for no grant).
//   cfg channel    : cfg_valid / cfg_ready (always ready), cfg_index picks
//                    the register, cfg_data carries the value. Write only
//                    while no request is outstanding.
//   Results are registered on acceptance. Throughput is one request per cycle
//   while item_stall is low; the four lane units and the merge stage resolve
//   a request as it is accepted, and the pointer and ages update at that edge.
//   A single output register holds the result: while it is full and the
//   receiver stalls, item_stall is raised and the request waits.
//   Reset clears the pointer and all ages and loads the register defaults.
// ----------------------------------------------------------------------------
module priority_round_robin_lane_arbiter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [prla_pkg::OP_BITS-1:0]         operation,
	input  logic [prla_pkg::LANE_COUNT-1:0]      ready_mask,
	input  logic [prla_pkg::LANE_COUNT-1:0]      blocked_mask,
	input  logic [prla_pkg::LANE_COUNT-1:0]      emergency_mask,
	input  logic [prla_pkg::QUEUE_BITS-1:0]      queue_length_0,
	input  logic [prla_pkg::QUEUE_BITS-1:0]      queue_length_1,
	input  logic [prla_pkg::QUEUE_BITS-1:0]      queue_length_2,
	input  logic [prla_pkg::QUEUE_BITS-1:0]      queue_length_3,
	input  logic [prla_pkg::LANE_BITS-1:0]       target_lane,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 grant_valid,
	output logic [prla_pkg::LANE_BITS-1:0]       grant_lane,
	output logic [prla_pkg::CLASS_BITS-1:0]      grant_class,
	output logic [prla_pkg::QUANTUM_BITS-1:0]    quantum,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [prla_pkg::INDEX_BITS-1:0]      cfg_index,
	input  logic [prla_pkg::CFG_BITS-1:0]        cfg_data
);
	import prla_pkg::*;

	cfg_t                    cfg_q;
	logic [LANE_BITS-1:0]    next_pointer_q;
	logic [AGE_BITS-1:0]     lane_age_q [LANE_COUNT];
	logic [AGE_BITS-1:0]     age_next [LANE_COUNT];
	logic [QUEUE_BITS-1:0]   queue_len [LANE_COUNT];
	lane_info_t              info [LANE_COUNT];
	pick_t                   pick;
	logic                    accept;
	logic                    result_valid_q;
	logic                    grant_valid_q;
	logic [LANE_BITS-1:0]    grant_lane_q;
	logic [CLASS_BITS-1:0]   grant_class_q;
	logic [QUANTUM_BITS-1:0] quantum_q;

	assign queue_len[0] = queue_length_0;
	assign queue_len[1] = queue_length_1;
	assign queue_len[2] = queue_length_2;
	assign queue_len[3] = queue_length_3;

	assign cfg_ready  = 1'b1;
	assign item_stall = result_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		prla_lane u_lane (
			.cfg          (cfg_q),
			.operation    (operation),
			.is_target    (target_lane == LANE_BITS'(g)),
			.ready        (ready_mask[g]),
			.blocked      (blocked_mask[g]),
			.emergency    (emergency_mask[g]),
			.lane_queue   (queue_len[g]),
			.age          (lane_age_q[g]),
			.info         (info[g]),
			.age_next     (age_next[g])
		);
	end

	prla_merge u_merge (
		.cfg     (cfg_q),
		.info    (info),
		.pointer (next_pointer_q),
		.pick    (pick)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode                 <= MODE_PLAIN;
			cfg_q.busy_queue_threshold <= CFG_BITS'(3);
			cfg_q.aging_limit          <= CFG_BITS'(30);
			cfg_q.heavy_load_average   <= CFG_BITS'(8);
			cfg_q.light_load_average   <= CFG_BITS'(2);
			cfg_q.quantum_default      <= QUANTUM_BITS'(3);
			cfg_q.quantum_heavy        <= QUANTUM_BITS'(2);
			cfg_q.quantum_light        <= QUANTUM_BITS'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        cfg_q.mode                 <= cfg_data[MODE_BITS-1:0];
				REG_BUSY_THRESH: cfg_q.busy_queue_threshold <= cfg_data;
				REG_AGING_LIMIT: cfg_q.aging_limit          <= cfg_data;
				REG_HEAVY_AVG:   cfg_q.heavy_load_average   <= cfg_data;
				REG_LIGHT_AVG:   cfg_q.light_load_average   <= cfg_data;
				REG_Q_DEFAULT:   cfg_q.quantum_default      <= cfg_data[QUANTUM_BITS-1:0];
				REG_Q_HEAVY:     cfg_q.quantum_heavy        <= cfg_data[QUANTUM_BITS-1:0];
				REG_Q_LIGHT:     cfg_q.quantum_light        <= cfg_data[QUANTUM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// arbiter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pointer_q <= '0;
			for (int i = 0; i < LANE_COUNT; i++) begin
				lane_age_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				lane_age_q[i] <= age_next[i];
			end
			case (operation)
				OP_SCHEDULE: next_pointer_q <= pick.next_pointer;
				OP_PREEMPT:  next_pointer_q <= target_lane;
				default:     next_pointer_q <= next_pointer_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (operation)
				OP_SCHEDULE: begin
					grant_valid_q <= pick.found;
					grant_lane_q  <= pick.found ? pick.lane : '0;
					grant_class_q <= pick.found ? pick.cls : CLASS_EMERGENCY;
					quantum_q     <= pick.found ? pick.quantum : '0;
				end
				OP_PREEMPT: begin
					grant_valid_q <= 1'b1;
					grant_lane_q  <= target_lane;
					grant_class_q <= CLASS_EMERGENCY;
					quantum_q     <= cfg_q.quantum_default;
				end
				default: begin
					grant_valid_q <= 1'b0;
					grant_lane_q  <= '0;
					grant_class_q <= CLASS_EMERGENCY;
					quantum_q     <= '0;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign grant_valid  = grant_valid_q;
	assign grant_lane   = grant_lane_q;
	assign grant_class  = grant_class_q;
	assign quantum      = quantum_q;

	// stall towards the item side only when a result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stall raised with no result held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !grant_valid) |-> (grant_lane == '0 && quantum == '0
			&& grant_class == CLASS_EMERGENCY))
		else $error("empty result carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_PREEMPT) |=> (next_pointer_q == $past(target_lane)))
		else $error("preempt did not move the pointer to the target lane");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_TICK) |=> (lane_age_q[0] >= $past(lane_age_q[0])))
		else $error("tick lowered a lane age");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_SCHEDULE && !pick.found) |=> $stable(next_pointer_q))
		else $error("pointer moved on a schedule with no grant");

endmodule
